[design/abp_pkg.sv]
// abp_pkg: shared types and constants for the argb alpha blend pixel block
// beat structs for both channels, register index codes, config bundle
`default_nettype none

package abp_pkg;

  localparam int unsigned PixW   = 32;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumCol = 3;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [ChanW-1:0]  Full      = 8'd255;
  localparam logic [15:0]       Half      = 16'd128;
  localparam logic [PixW-1:0]   AlphaMask = 32'hff00_0000;
  localparam logic [ChanW-1:0]  GaReset   = 8'd255;

  typedef enum logic {
    RegBlendMode   = 1'b0,
    RegGlobalAlpha = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ModeCopy  = 1'b0,
    ModeBlend = 1'b1
  } blend_mode_e;

  typedef struct packed {
    logic [PixW-1:0] src_pixel;
    logic [PixW-1:0] dst_pixel;
    logic            row_end;
  } in_beat_t;

  typedef struct packed {
    logic [PixW-1:0] out_pixel;
    logic            write_enable;
    logic            row_end_out;
  } out_beat_t;

  typedef struct packed {
    blend_mode_e      blend_mode;
    logic [ChanW-1:0] layer_alpha;
  } cfg_t;

  // second half of the rounded divide by 255: (t + (t >> 8)) >> 8
  function automatic logic [ChanW:0] mul8_fin(input logic [15:0] t);
    logic [16:0] s;
    s = {1'b0, t} + {9'd0, t[15:8]};
    return s[16:8];
  endfunction

endpackage

`default_nettype wire

[design/abp_regs.sv]
// abp_regs: apb-style configuration registers (blend mode, global alpha)
// depends on abp_pkg
`default_nettype none

module abp_regs import abp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegBlendMode:   cfg_d.blend_mode  = blend_mode_e'(pwdata[0]);
        RegGlobalAlpha: cfg_d.layer_alpha = pwdata[ChanW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegBlendMode:   prdata = {{(DataW-1){1'b0}}, cfg_q.blend_mode};
      RegGlobalAlpha: prdata = {{(DataW-ChanW){1'b0}}, cfg_q.layer_alpha};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blend_mode  <= ModeCopy;
      cfg_q.layer_alpha <= GaReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[design/abp_pipe.sv]
// abp_pipe: four-stage blend datapath with per-stage valid and bubble collapse
// depends on abp_pkg
`default_nettype none

module abp_pipe import abp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  // stage valids and readies
  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  assign r4 = !v4_q | out_ready_i;
  assign r3 = !v3_q | r4;
  assign r2 = !v2_q | r3;
  assign r1 = !v1_q | r2;
  assign in_ready_o = r1;

  // stage 1: alpha product
  in_beat_t    b1_q;
  logic [15:0] ta1_q;
  // stage 2: effective alpha
  in_beat_t         b2_q;
  logic [ChanW-1:0] ea2_q;
  // stage 3: channel products
  in_beat_t         b3_q;
  logic [ChanW-1:0] ea3_q;
  logic [15:0]      ps3_q [NumCol];
  logic [15:0]      pd3_q [NumCol];
  logic [15:0]      ps3_d [NumCol];
  logic [15:0]      pd3_d [NumCol];
  // stage 4: output
  out_beat_t out4_q, out4_d;

  logic [ChanW:0]   ea_full;
  logic [ChanW-1:0] ea_inv;

  assign ea_full = mul8_fin(ta1_q);
  assign ea_inv  = Full - ea2_q;

  always_comb begin
    for (int c = 0; c < NumCol; c++) begin
      ps3_d[c] = {8'd0, b2_q.src_pixel[c*ChanW +: ChanW]} * {8'd0, ea2_q} + Half;
      pd3_d[c] = {8'd0, b2_q.dst_pixel[c*ChanW +: ChanW]} * {8'd0, ea_inv} + Half;
    end
  end

  always_comb begin
    logic [ChanW:0]   sum;
    logic [PixW-1:0]  mix;
    mix = AlphaMask;
    for (int c = 0; c < NumCol; c++) begin
      sum = mul8_fin(ps3_q[c]) + mul8_fin(pd3_q[c]);
      mix[c*ChanW +: ChanW] = sum[ChanW] ? Full : sum[ChanW-1:0];
    end
    out4_d.row_end_out = b3_q.row_end;
    if (cfg_i.blend_mode == ModeCopy) begin
      out4_d.out_pixel    = b3_q.src_pixel | AlphaMask;
      out4_d.write_enable = 1'b1;
    end else if (cfg_i.layer_alpha == '0 || ea3_q == '0) begin
      out4_d.out_pixel    = b3_q.dst_pixel;
      out4_d.write_enable = 1'b0;
    end else if (ea3_q == Full) begin
      out4_d.out_pixel    = b3_q.src_pixel | AlphaMask;
      out4_d.write_enable = 1'b1;
    end else begin
      out4_d.out_pixel    = mix;
      out4_d.write_enable = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      b1_q  <= in_data_i;
      ta1_q <= {8'd0, in_data_i.src_pixel[PixW-1 -: ChanW]} * {8'd0, cfg_i.layer_alpha}
               + Half;
    end
    if (r2 && v1_q) begin
      b2_q  <= b1_q;
      ea2_q <= ea_full[ChanW-1:0];
    end
    if (r3 && v2_q) begin
      b3_q  <= b2_q;
      ea3_q <= ea2_q;
      ps3_q <= ps3_d;
      pd3_q <= pd3_d;
    end
    if (r4 && v3_q) begin
      out4_q <= out4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out4_q;

endmodule

`default_nettype wire

[design/argb_alpha_blend_pixel.sv]
// argb_alpha_blend_pixel: source-over blend of one argb pixel per beat
// throughput one beat per cycle while out_ready_i does not hold the output stage
// four register stages: alpha product, effective alpha, channel products, output
// rst_ni clears stage valids and sets blend_mode 0, layer alpha 255
// depends on abp_pkg, abp_regs, abp_pipe
`default_nettype none

module argb_alpha_blend_pixel import abp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_beat_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_beat_t             out_data_o
);

  cfg_t cfg;

  abp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  abp_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// testbench: self-checking bench for argb_alpha_blend_pixel, directed beats then random phases
// scoreboard class with its own source-over predictor; depends on abp_pkg and the block rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import abp_pkg::*;

  localparam int unsigned PipeLat    = 4;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned PhaseBeats = 48;
  localparam int unsigned NumPhases  = 9;

  class pixel_scoreboard;
    cfg_t        cfg;
    out_beat_t   expected_pixels[$];
    int unsigned mismatches;

    function new();
      cfg.blend_mode  = ModeCopy;
      cfg.layer_alpha = GaReset;
      mismatches      = 0;
    endfunction

    // x*y/255 rounded to nearest
    function logic [ChanW-1:0] div255(input logic [ChanW-1:0] x, input logic [ChanW-1:0] y);
      logic [16:0] t;
      logic [16:0] u;
      t = x * y + 17'd128;
      u = (t + (t >> 8)) >> 8;
      return u[ChanW-1:0];
    endfunction

    function out_beat_t blended_pixel(input in_beat_t b);
      out_beat_t        r;
      logic [ChanW-1:0] ea;
      logic [ChanW:0]   sum;
      r.row_end_out = b.row_end;
      if (cfg.blend_mode == ModeCopy) begin
        r.out_pixel    = b.src_pixel | AlphaMask;
        r.write_enable = 1'b1;
      end else begin
        ea = div255(b.src_pixel[31:24], cfg.layer_alpha);
        if (cfg.layer_alpha == '0 || ea == '0) begin
          r.out_pixel    = b.dst_pixel;
          r.write_enable = 1'b0;
        end else if (ea == Full) begin
          r.out_pixel    = b.src_pixel | AlphaMask;
          r.write_enable = 1'b1;
        end else begin
          r.out_pixel    = AlphaMask;
          r.write_enable = 1'b1;
          for (int c = 0; c < NumCol; c++) begin
            sum = div255(b.src_pixel[8*c +: 8], ea) + div255(b.dst_pixel[8*c +: 8], Full - ea);
            r.out_pixel[8*c +: 8] = (sum > {1'b0, Full}) ? Full : sum[ChanW-1:0];
          end
        end
      end
      return r;
    endfunction

    function void note_pixel_in(input in_beat_t b);
      expected_pixels.push_back(blended_pixel(b));
    endfunction

    function void check_pixel_out(input out_beat_t got);
      out_beat_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected output beat: pixel %h we %b row_end %b",
                   got.out_pixel, got.write_enable, got.row_end_out);
        end
        return;
      end
      want = expected_pixels.pop_front();
      if (got.out_pixel !== want.out_pixel || got.write_enable !== want.write_enable ||
          got.row_end_out !== want.row_end_out) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: pixel exp %h got %h, we exp %b got %b, row_end exp %b got %b",
                   want.out_pixel, got.out_pixel, want.write_enable, got.write_enable,
                   want.row_end_out, got.row_end_out);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_ready_o;
  in_beat_t         in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_beat_t        out_data_o;

  logic        snd_idle;
  logic        rcv_idle;
  logic        hold_req;
  int unsigned quiet_cycles = 0;

  pixel_scoreboard sb = new();

  argb_alpha_blend_pixel dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_pixel_in(in_data_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_pixel_out(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= StallLimit);
    $display("Some tests failed");
    $finish;
  end

  // output side: random back-pressure bursts and one long hold
  initial begin : receiver
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rcv_idle && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 12);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic in_beat_t make_beat(input logic [PixW-1:0] src, input logic [PixW-1:0] dst,
                                         input logic row_end);
    in_beat_t b;
    b.src_pixel = src;
    b.dst_pixel = dst;
    b.row_end   = row_end;
    return b;
  endfunction

  function automatic logic [ChanW-1:0] rand_alpha();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'($urandom_range(1, 3));
      3:       return 8'($urandom_range(252, 254));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input in_beat_t b);
    int gap;
    if (snd_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegBlendMode:   sb.cfg.blend_mode  = blend_mode_e'(value[0]);
      RegGlobalAlpha: sb.cfg.layer_alpha = value[ChanW-1:0];
      default: ;
    endcase
  endtask

  // upper bits carry junk, only the low bits of each register count
  task automatic set_blend(input blend_mode_e mode, input logic [ChanW-1:0] ga);
    logic [DataW-1:0] junk;
    junk = $urandom;
    write_reg(RegBlendMode, {junk[DataW-1:1], mode});
    junk = $urandom;
    write_reg(RegGlobalAlpha, {junk[DataW-1:ChanW], ga});
  endtask

  initial begin : stimulus
    in_beat_t         b;
    blend_mode_e      mode;
    logic [ChanW-1:0] ga;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    snd_idle   = 1'b0;
    rcv_idle   = 1'b0;
    hold_req   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: copy mode
    send_pixel(make_beat(32'h0000_0000, 32'hffff_ffff, 1'b0));
    send_pixel(make_beat(32'hffff_ffff, 32'h0000_0000, 1'b1));
    send_pixel(make_beat(32'h0012_3456, 32'h89ab_cdef, 1'b0));
    wait_drained();

    // blend with global alpha still at its reset value
    write_reg(RegBlendMode, {31'd0, ModeBlend});
    send_pixel(make_beat(32'h00ff_ffff, 32'h1234_5678, 1'b0));
    send_pixel(make_beat(32'hff12_3456, 32'hffff_ffff, 1'b1));
    send_pixel(make_beat(32'h01ff_ffff, 32'h0000_0000, 1'b0));
    send_pixel(make_beat(32'h80ff_ffff, 32'hffff_ffff, 1'b1));
    send_pixel(make_beat(32'hfe00_0000, 32'hffff_ffff, 1'b0));
    send_pixel(make_beat(32'h7fff_00ff, 32'h00ff_00ff, 1'b0));
    send_pixel(make_beat(32'h8000_0000, 32'h0000_0000, 1'b1));
    wait_drained();

    set_blend(ModeBlend, 8'd0);
    send_pixel(make_beat(32'hffff_ffff, 32'h0a0b_0c0d, 1'b0));
    send_pixel(make_beat(32'h0000_0000, 32'hffff_ffff, 1'b1));
    wait_drained();

    set_blend(ModeBlend, 8'd1);
    send_pixel(make_beat(32'hffab_cdef, 32'h0102_0304, 1'b0));
    send_pixel(make_beat(32'h7fff_ffff, 32'hffff_ffff, 1'b1));
    send_pixel(make_beat(32'h80ff_ffff, 32'h0000_0000, 1'b0));
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      mode = ModeBlend;
      ga   = 8'($urandom);
      case (p)
        0: mode = ModeCopy;
        1: ga = 8'd255;
        2: ga = 8'd0;
        3: ga = 8'd1;
        4: ga = 8'd254;
        7: begin
          mode = ModeCopy;
          ga   = 8'd0;
        end
        default: ;
      endcase
      set_blend(mode, ga);
      snd_idle = (p != 5 && p != NumPhases - 1);
      rcv_idle = (p != NumPhases - 1);
      hold_req = (p == 5);
      for (int i = 0; i < PhaseBeats; i++) begin
        b.src_pixel          = $urandom;
        b.src_pixel[31:24]   = rand_alpha();
        b.dst_pixel          = $urandom;
        b.row_end            = ($urandom_range(0, 7) == 0);
        send_pixel(b);
      end
      wait_drained();
    end

    repeat (PipeLat + 4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
